// ===== rtl/u8cyr_pkg.sv =====
`timescale 1ns / 1ps
// shared constants for the utf-8 / cyrillic encoding detect unit
// no dependencies

package u8cyr_pkg;

  localparam int BYTE_W  = 8;
  localparam int CLASS_W = 2;
  localparam int PEND_W  = 2;

  // byte masks and patterns for lead byte classification
  localparam logic [BYTE_W-1:0] MASK_TOP1 = 8'h80;
  localparam logic [BYTE_W-1:0] MASK_TOP2 = 8'hC0;
  localparam logic [BYTE_W-1:0] MASK_TOP3 = 8'hE0;
  localparam logic [BYTE_W-1:0] MASK_TOP4 = 8'hF0;
  localparam logic [BYTE_W-1:0] MASK_TOP5 = 8'hF8;

  localparam logic [BYTE_W-1:0] PAT_CONT  = 8'h80;
  localparam logic [BYTE_W-1:0] PAT_LEAD2 = 8'hC0;
  localparam logic [BYTE_W-1:0] PAT_LEAD3 = 8'hE0;
  localparam logic [BYTE_W-1:0] PAT_LEAD4 = 8'hF0;

  // range limits for the single-byte code page flags
  localparam logic [BYTE_W-1:0] DOS_LO1  = 8'h80;
  localparam logic [BYTE_W-1:0] DOS_HI1  = 8'hAF;
  localparam logic [BYTE_W-1:0] DOS_LO2  = 8'hE0;
  localparam logic [BYTE_W-1:0] DOS_HI2  = 8'hEF;
  localparam logic [BYTE_W-1:0] HIGH_LO  = 8'hC0;
  localparam logic [BYTE_W-1:0] CYR_YO_U = 8'hA8;
  localparam logic [BYTE_W-1:0] CYR_YO_L = 8'hB8;

  // report style register values
  localparam logic STYLE_NAMED   = 1'b0;
  localparam logic STYLE_NUMERIC = 1'b1;

  // named verdict codes
  localparam logic [CLASS_W-1:0] VERDICT_UTF8  = 2'd0;
  localparam logic [CLASS_W-1:0] VERDICT_CP866 = 2'd1;
  localparam logic [CLASS_W-1:0] VERDICT_WIN   = 2'd2;
  localparam logic [CLASS_W-1:0] VERDICT_KOI8R = 2'd3;

  // numeric code values
  localparam logic [CLASS_W-1:0] CODE_ASCII    = 2'd0;
  localparam logic [CLASS_W-1:0] CODE_UTF8     = 2'd1;
  localparam logic [CLASS_W-1:0] CODE_CYRILLIC = 2'd2;

  // continuation counts due after a lead byte
  localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
  localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
  localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;
  localparam logic [PEND_W-1:0] PEND_THREE = 2'd3;

endpackage

// ===== rtl/utf8_and_cyrillic_encoding_detect_unit.sv =====
`timescale 1ns / 1ps
// top level of the utf-8 / cyrillic encoding detect unit
// depends on u8cyr_pkg

// Takes one string byte per cycle on the input channel, with no bubbles: a
// byte transfer updates the utf-8 structure check and the sticky code page
// flags in the same cycle. A zero byte ends the string; its result (encoding
// class and utf-8 valid bit) appears in the output register on the next
// cycle, and the string state is cleared so the next string's first byte
// can follow right behind the terminator. The input stalls only while a
// result sits in the output register and the output side is not taking it.
// The user must write report_style through the configuration channel only while idle; the block does not enforce this.
module utf8_and_cyrillic_encoding_detect_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [u8cyr_pkg::BYTE_W-1:0]    input_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [u8cyr_pkg::CLASS_W-1:0]   encoding_class,
  output logic                            utf8_valid,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_data
);

  logic                           report_style;
  logic [u8cyr_pkg::PEND_W-1:0]   pending;
  logic                           utf8_failed;
  logic                           saw_dos_range;
  logic                           saw_high_range;
  logic                           saw_cyrillic;

  logic [u8cyr_pkg::PEND_W-1:0]   pending_next;
  logic                           utf8_failed_next;
  logic                           dos_hit;
  logic                           high_hit;
  logic                           cyr_hit;
  logic                           in_xfer;
  logic                           is_term;
  logic                           str_valid;
  logic [u8cyr_pkg::CLASS_W-1:0]  class_next;

  assign in_ready  = !out_valid || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign is_term   = (input_byte == '0);
  assign cfg_ready = 1'b1;

  // structure check for a non-terminator byte
  always_comb begin
    pending_next     = pending;
    utf8_failed_next = utf8_failed;
    if (!utf8_failed) begin
      if (pending != u8cyr_pkg::PEND_NONE) begin
        if ((input_byte & u8cyr_pkg::MASK_TOP2) == u8cyr_pkg::PAT_CONT) begin
          pending_next = pending - u8cyr_pkg::PEND_ONE;
        end else begin
          utf8_failed_next = 1'b1;
          pending_next     = u8cyr_pkg::PEND_NONE;
        end
      end else if ((input_byte & u8cyr_pkg::MASK_TOP1) == '0) begin
        pending_next = u8cyr_pkg::PEND_NONE;
      end else if ((input_byte & u8cyr_pkg::MASK_TOP3) == u8cyr_pkg::PAT_LEAD2) begin
        pending_next = u8cyr_pkg::PEND_ONE;
      end else if ((input_byte & u8cyr_pkg::MASK_TOP4) == u8cyr_pkg::PAT_LEAD3) begin
        pending_next = u8cyr_pkg::PEND_TWO;
      end else if ((input_byte & u8cyr_pkg::MASK_TOP5) == u8cyr_pkg::PAT_LEAD4) begin
        pending_next = u8cyr_pkg::PEND_THREE;
      end else begin
        // stray continuation or 0xf8 and up as a lead
        utf8_failed_next = 1'b1;
      end
    end
  end

  assign dos_hit  = ((input_byte >= u8cyr_pkg::DOS_LO1) && (input_byte <= u8cyr_pkg::DOS_HI1))
                 || ((input_byte >= u8cyr_pkg::DOS_LO2) && (input_byte <= u8cyr_pkg::DOS_HI2));
  assign high_hit = (input_byte >= u8cyr_pkg::HIGH_LO);
  assign cyr_hit  = high_hit || (input_byte == u8cyr_pkg::CYR_YO_U)
                 || (input_byte == u8cyr_pkg::CYR_YO_L);

  // verdict on the terminator
  assign str_valid = !utf8_failed && (pending == u8cyr_pkg::PEND_NONE);

  always_comb begin
    if (report_style == u8cyr_pkg::STYLE_NAMED) begin
      if (str_valid) begin
        class_next = u8cyr_pkg::VERDICT_UTF8;
      end else if (saw_dos_range && !saw_high_range) begin
        class_next = u8cyr_pkg::VERDICT_CP866;
      end else if (saw_high_range && saw_dos_range) begin
        class_next = u8cyr_pkg::VERDICT_KOI8R;
      end else begin
        // high range only, or no flag at all
        class_next = u8cyr_pkg::VERDICT_WIN;
      end
    end else begin
      if (str_valid) begin
        class_next = u8cyr_pkg::CODE_UTF8;
      end else if (saw_cyrillic) begin
        class_next = u8cyr_pkg::CODE_CYRILLIC;
      end else begin
        class_next = u8cyr_pkg::CODE_ASCII;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      report_style <= u8cyr_pkg::STYLE_NAMED;
    end else if (cfg_valid && cfg_ready) begin
      report_style <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending        <= u8cyr_pkg::PEND_NONE;
      utf8_failed    <= 1'b0;
      saw_dos_range  <= 1'b0;
      saw_high_range <= 1'b0;
      saw_cyrillic   <= 1'b0;
    end else if (in_xfer) begin
      if (is_term) begin
        pending        <= u8cyr_pkg::PEND_NONE;
        utf8_failed    <= 1'b0;
        saw_dos_range  <= 1'b0;
        saw_high_range <= 1'b0;
        saw_cyrillic   <= 1'b0;
      end else begin
        pending        <= pending_next;
        utf8_failed    <= utf8_failed_next;
        saw_dos_range  <= saw_dos_range || dos_hit;
        saw_high_range <= saw_high_range || high_hit;
        saw_cyrillic   <= saw_cyrillic || cyr_hit;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer && is_term) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && is_term) begin
      encoding_class <= class_next;
      utf8_valid     <= str_valid;
    end
  end

endmodule

// ===== sim/tb_utf8_and_cyrillic_encoding_detect_unit.sv =====
`timescale 1ns / 1ps
// testbench for the utf-8 / cyrillic encoding detect unit: directed and random strings
// through the byte channel, results checked against a cycle-free predictor
// depends on u8cyr_pkg and rtl/utf8_and_cyrillic_encoding_detect_unit.sv

module tb_utf8_and_cyrillic_encoding_detect_unit;

  typedef logic [u8cyr_pkg::BYTE_W-1:0] byte_t;

  typedef struct packed {
    logic [u8cyr_pkg::CLASS_W-1:0] enc_class;
    logic                          valid;
  } verdict_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  byte_t                         input_byte = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [u8cyr_pkg::CLASS_W-1:0] encoding_class;
  logic                          utf8_valid;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic                          cfg_data = 1'b0;

  // bytes waiting to be sent and verdicts waiting to come out
  byte_t    byte_q[$];
  verdict_t verdict_q[$];
  verdict_t want;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned bytes_queued = 0;
  int unsigned bytes_taken = 0;
  int unsigned strings_done = 0;
  int unsigned strings_valid = 0;
  int unsigned err_count = 0;

  // predictor copy of the string state and the style register
  logic                         style_reg = u8cyr_pkg::STYLE_NAMED;
  logic [u8cyr_pkg::PEND_W-1:0] pend_cont = u8cyr_pkg::PEND_NONE;
  logic                         str_failed = 1'b0;
  logic                         seen_dos = 1'b0;
  logic                         seen_high = 1'b0;
  logic                         seen_cyr = 1'b0;

  utf8_and_cyrillic_encoding_detect_unit uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .input_byte     (input_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .encoding_class (encoding_class),
    .utf8_valid     (utf8_valid),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // advance the predicted string state by one byte; a zero byte yields a verdict
  task automatic track_byte(input byte_t b);
    verdict_t v;
    logic     ok;
    if (b != '0) begin
      if (!str_failed) begin
        if (pend_cont != u8cyr_pkg::PEND_NONE) begin
          if ((b & u8cyr_pkg::MASK_TOP2) == u8cyr_pkg::PAT_CONT) begin
            pend_cont = pend_cont - u8cyr_pkg::PEND_ONE;
          end else begin
            // missing continuation: byte is not taken as a new lead
            str_failed = 1'b1;
            pend_cont = u8cyr_pkg::PEND_NONE;
          end
        end else if ((b & u8cyr_pkg::MASK_TOP1) == '0) begin
          // plain ascii, nothing due
        end else if ((b & u8cyr_pkg::MASK_TOP3) == u8cyr_pkg::PAT_LEAD2) begin
          pend_cont = u8cyr_pkg::PEND_ONE;
        end else if ((b & u8cyr_pkg::MASK_TOP4) == u8cyr_pkg::PAT_LEAD3) begin
          pend_cont = u8cyr_pkg::PEND_TWO;
        end else if ((b & u8cyr_pkg::MASK_TOP5) == u8cyr_pkg::PAT_LEAD4) begin
          pend_cont = u8cyr_pkg::PEND_THREE;
        end else begin
          str_failed = 1'b1;
        end
      end
      if ((b >= u8cyr_pkg::DOS_LO1 && b <= u8cyr_pkg::DOS_HI1)
          || (b >= u8cyr_pkg::DOS_LO2 && b <= u8cyr_pkg::DOS_HI2)) seen_dos = 1'b1;
      if (b >= u8cyr_pkg::HIGH_LO) seen_high = 1'b1;
      if (b >= u8cyr_pkg::HIGH_LO || b == u8cyr_pkg::CYR_YO_U || b == u8cyr_pkg::CYR_YO_L)
        seen_cyr = 1'b1;
    end else begin
      ok = !str_failed && pend_cont == u8cyr_pkg::PEND_NONE;
      if (style_reg == u8cyr_pkg::STYLE_NAMED) begin
        if (ok) v.enc_class = u8cyr_pkg::VERDICT_UTF8;
        else if (seen_dos && !seen_high) v.enc_class = u8cyr_pkg::VERDICT_CP866;
        else if (seen_high && !seen_dos) v.enc_class = u8cyr_pkg::VERDICT_WIN;
        else if (seen_high) v.enc_class = u8cyr_pkg::VERDICT_KOI8R;
        else v.enc_class = u8cyr_pkg::VERDICT_WIN;
      end else begin
        if (ok) v.enc_class = u8cyr_pkg::CODE_UTF8;
        else if (seen_cyr) v.enc_class = u8cyr_pkg::CODE_CYRILLIC;
        else v.enc_class = u8cyr_pkg::CODE_ASCII;
      end
      v.valid = ok;
      verdict_q.push_back(v);
      pend_cont = u8cyr_pkg::PEND_NONE;
      str_failed = 1'b0;
      seen_dos = 1'b0;
      seen_high = 1'b0;
      seen_cyr = 1'b0;
    end
  endtask

  // byte driver: a new byte is offered only once the previous transfer is done
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        track_byte(input_byte);
        bytes_taken++;
      end
      if (!in_valid || in_ready) begin
        if (byte_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          input_byte <= byte_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result class %0d valid %0d", $time, encoding_class,
                   utf8_valid);
        end else begin
          want = verdict_q.pop_front();
          strings_done++;
          if (want.valid) strings_valid++;
          if (encoding_class !== want.enc_class) begin
            err_count++;
            $display("%0t: encoding_class mismatch, expected %0d got %0d", $time,
                     want.enc_class, encoding_class);
          end
          if (utf8_valid !== want.valid) begin
            err_count++;
            $display("%0t: utf8_valid mismatch, expected %0d got %0d", $time, want.valid,
                     utf8_valid);
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic byte_t rand_cont();
    return u8cyr_pkg::PAT_CONT | byte_t'($urandom_range(0, 63));
  endfunction

  function automatic byte_t rand_lead(input int unsigned n);
    if (n == 1) return u8cyr_pkg::PAT_LEAD2 | byte_t'($urandom_range(0, 31));
    if (n == 2) return u8cyr_pkg::PAT_LEAD3 | byte_t'($urandom_range(0, 15));
    return u8cyr_pkg::PAT_LEAD4 | byte_t'($urandom_range(0, 7));
  endfunction

  task automatic put_byte(input byte_t b);
    byte_q.push_back(b);
    bytes_queued++;
  endtask

  // one well-formed character of one to four bytes
  task automatic put_char();
    int unsigned n;
    n = $urandom_range(0, 3);
    if (n == 0) begin
      put_byte(byte_t'($urandom_range(1, 127)));
    end else begin
      put_byte(rand_lead(n));
      repeat (n) put_byte(rand_cont());
    end
  endtask

  task automatic put_random_string();
    int unsigned kind;
    int unsigned n;
    int unsigned k;
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      repeat ($urandom_range(0, 6)) put_char();
    end else if (kind == 7) begin
      // raw code page text: any non-zero bytes
      repeat ($urandom_range(1, 8)) put_byte(byte_t'($urandom_range(1, 255)));
    end else begin
      // sequence cut short, then an early end or an interrupting byte
      repeat ($urandom_range(0, 3)) put_char();
      n = $urandom_range(1, 3);
      k = $urandom_range(0, n - 1);
      put_byte(rand_lead(n));
      repeat (k) put_byte(rand_cont());
      if (kind == 9) begin
        if ($urandom_range(0, 1)) put_byte(byte_t'($urandom_range(1, 127)));
        else put_byte(byte_t'($urandom_range(u8cyr_pkg::HIGH_LO, 255)));
        repeat ($urandom_range(0, 3)) put_char();
      end
    end
    put_byte('0);
  endtask

  task automatic write_style(input logic v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    style_reg = v;
  endtask

  // wait for every queued byte to transfer and every verdict to come out
  task automatic drain();
    while (bytes_taken != bytes_queued || verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_phase(input logic style, input int unsigned send_pct,
                              input int unsigned recv_pct);
    int unsigned start;
    write_style(style);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    start = bytes_queued;
    while (bytes_queued - start < 132) put_random_string();
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed strings, named verdict style, no idling
    write_style(u8cyr_pkg::STYLE_NAMED);
    put_byte('0);                                                  // empty string
    put_byte(8'h7F); put_byte('0);
    put_byte(8'hD0); put_byte(8'h9F); put_byte('0);                // two-byte char
    put_byte(8'hF0); put_byte(8'h9F); put_byte(8'h98); put_byte(8'h80); put_byte('0);
    put_byte(8'hE0); put_byte(8'h41); put_byte('0);                // missing continuation
    put_byte(8'h80); put_byte('0);                                 // stray continuation
    put_byte(8'hFF); put_byte('0);                                 // invalid lead
    put_byte(8'hC3); put_byte('0);                                 // early end
    put_byte(8'hB5); put_byte('0);                                 // fails, no range flag
    put_byte(8'hB8); put_byte('0);
    drain();

    random_phase(u8cyr_pkg::STYLE_NUMERIC, 0, 0);
    random_phase(u8cyr_pkg::STYLE_NAMED, 74, 0);
    random_phase(u8cyr_pkg::STYLE_NUMERIC, 0, 74);
    random_phase(u8cyr_pkg::STYLE_NAMED, 6, 6);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (10) @(posedge clk);
    $display("sent %0d bytes in %0d strings (%0d valid utf-8) over both report styles",
             bytes_taken, strings_done, strings_valid);
    $display("idle mixes: none, sender 74%%, receiver 74%%, both 6%%; %0d errors, %0d left",
             err_count, verdict_q.size());
    if (err_count == 0 && verdict_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, verdict_q.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
